/* rtl/mecanum_motion_ramp_core_macros.svh */
// Assertion helpers for the motion ramp RTL.
`ifndef MECANUM_MOTION_RAMP_CORE_MACROS_SVH
`define MECANUM_MOTION_RAMP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while rst is high.
`define MMR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted while rst is high.
`define MMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mmr_pkg.sv */
package mmr_pkg;

  localparam int WHEELS = 4;

  localparam logic CMD_MOTION = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [3:0] MV_IDLE     = 4'd0;
  localparam logic [3:0] MV_AHEAD    = 4'd1;
  localparam logic [3:0] MV_REVERSE  = 4'd2;
  localparam logic [3:0] MV_SLIDE_L  = 4'd3;
  localparam logic [3:0] MV_SLIDE_R  = 4'd4;
  localparam logic [3:0] MV_DIAG_FR  = 4'd5;
  localparam logic [3:0] MV_DIAG_FL  = 4'd6;
  localparam logic [3:0] MV_DIAG_RR  = 4'd7;
  localparam logic [3:0] MV_DIAG_RL  = 4'd8;
  localparam logic [3:0] MV_SPIN_L   = 4'd9;
  localparam logic [3:0] MV_SPIN_R   = 4'd10;
  localparam logic [3:0] MV_PIVOT_FR = 4'd11;
  localparam logic [3:0] MV_PIVOT_FL = 4'd12;
  localparam logic [3:0] MV_PIVOT_RR = 4'd13;
  localparam logic [3:0] MV_PIVOT_RL = 4'd14;
  localparam logic [3:0] MV_HALT     = 4'd15;

  localparam logic [7:0]  COEF_RESET = 8'd1;
  localparam logic [14:0] STEP_MAX   = 15'h7fff;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'b00,
    SGN_POS  = 2'b01,
    SGN_NEG  = 2'b10
  } sign_t;

  // Element [w] is the sign applied to wheel w.
  typedef sign_t [WHEELS-1:0] pattern_t;

  function automatic pattern_t wheel_pattern(input logic [3:0] code);
    pattern_t pat;
    unique case (code)
      MV_AHEAD:    pat = '{SGN_POS,  SGN_POS,  SGN_POS,  SGN_POS};
      MV_REVERSE:  pat = '{SGN_NEG,  SGN_NEG,  SGN_NEG,  SGN_NEG};
      MV_SLIDE_L:  pat = '{SGN_NEG,  SGN_POS,  SGN_POS,  SGN_NEG};
      MV_SLIDE_R:  pat = '{SGN_POS,  SGN_NEG,  SGN_NEG,  SGN_POS};
      MV_DIAG_FR:  pat = '{SGN_POS,  SGN_ZERO, SGN_ZERO, SGN_POS};
      MV_DIAG_FL:  pat = '{SGN_ZERO, SGN_POS,  SGN_POS,  SGN_ZERO};
      MV_DIAG_RR:  pat = '{SGN_ZERO, SGN_NEG,  SGN_NEG,  SGN_ZERO};
      MV_DIAG_RL:  pat = '{SGN_NEG,  SGN_ZERO, SGN_ZERO, SGN_NEG};
      MV_SPIN_L:   pat = '{SGN_NEG,  SGN_POS,  SGN_NEG,  SGN_POS};
      MV_SPIN_R:   pat = '{SGN_POS,  SGN_NEG,  SGN_POS,  SGN_NEG};
      MV_PIVOT_FR: pat = '{SGN_ZERO, SGN_ZERO, SGN_POS,  SGN_NEG};
      MV_PIVOT_FL: pat = '{SGN_ZERO, SGN_ZERO, SGN_NEG,  SGN_POS};
      MV_PIVOT_RR: pat = '{SGN_POS,  SGN_NEG,  SGN_ZERO, SGN_ZERO};
      MV_PIVOT_RL: pat = '{SGN_NEG,  SGN_POS,  SGN_ZERO, SGN_ZERO};
      default:     pat = '{SGN_ZERO, SGN_ZERO, SGN_ZERO, SGN_ZERO};
    endcase
    return pat;
  endfunction

endpackage

/* rtl/mecanum_motion_ramp_core.sv */
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: command; tdata: motion,speed,interval
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: drive_0..drive_3
// cfg       | in  | cfg_we (no wait)             | cfg_wdata: ramp_coefficient
//
// One item per cycle sustained while no tick waits on the output. An accepted
// item is loaded into the input register, then the mixing/ramp logic (one
// 8x16 multiply plus per-wheel add and compare) updates state and, for a
// tick, loads the result register that drives m_axis_tvalid.
// rst is synchronous: pulses, targets and mode clear, coefficient returns to 1.
// A tick stalls in the input register only while the result register is full
// and not taken; motion items never wait on the output side.

`include "mecanum_motion_ramp_core_macros.svh"

module mecanum_motion_ramp_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [3:0] motion, [14:4] speed, [30:15] interval, [31] zero
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] drive_0, [31:16] drive_1,
                                      // [47:32] drive_2, [63:48] drive_3
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata       // ramp_coefficient
);
  import mmr_pkg::*;

  // Configuration.
  logic [7:0] ramp_coefficient;

  // Input register.
  logic        in_valid;
  logic        in_command;
  logic [3:0]  in_motion;
  logic [10:0] in_speed;
  logic [15:0] in_interval;

  // Motion state.
  logic [3:0]         mode;
  logic signed [15:0] present_pulse [WHEELS];
  logic signed [15:0] goal_pulse    [WHEELS];

  // Per-wheel results of the working stage.
  logic signed [15:0] present_next [WHEELS];
  logic signed [15:0] goal_next    [WHEELS];

  // Result register.
  logic        out_valid;
  logic [63:0] out_data;

  logic        s_accept;
  logic        advance;
  logic        is_tick;
  logic        is_stop;
  logic [23:0] step_product;
  logic [14:0] step;
  logic [14:0] pulse_mag;
  pattern_t    pattern;

  // Shorthands for the checks at the end.
  logic        tick_done;
  logic        motion_done;
  logic        new_mode;
  logic        goal_idle;
  logic        pulse_zero;

  assign is_tick  = (in_command == CMD_TICK);
  // Retire the held item unless it is a tick blocked by a full result register.
  assign advance  = in_valid && (!is_tick || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  assign is_stop = (in_motion == MV_IDLE) || (in_motion == MV_HALT);

  // Step size: coefficient times interval, clamped to the largest positive pulse.
  assign step_product = ramp_coefficient * in_interval;
  assign step = (step_product > {9'd0, STEP_MAX}) ? STEP_MAX : step_product[14:0];

  // Target magnitude is sixteen pulses per speed unit.
  assign pulse_mag = {in_speed, 4'd0};
  assign pattern   = wheel_pattern(in_motion);

  for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
    logic signed [17:0] cur_x;
    logic signed [17:0] tgt_x;
    logic signed [17:0] step_x;
    logic signed [17:0] moved;
    logic signed [17:0] diff;
    logic        [17:0] diff_mag;

    assign cur_x  = 18'(present_pulse[w]);
    assign tgt_x  = 18'(goal_pulse[w]);
    assign step_x = $signed({3'd0, step});

    // Move one step toward the target, then snap when within one step of it.
    assign moved    = (tgt_x > cur_x) ? cur_x + step_x : cur_x - step_x;
    assign diff     = moved - tgt_x;
    assign diff_mag = diff[17] ? 18'(-diff) : 18'(diff);

    always_comb begin
      if (present_pulse[w] == goal_pulse[w]) begin
        present_next[w] = present_pulse[w];
      end else if (diff_mag <= {3'd0, step}) begin
        present_next[w] = goal_pulse[w];
      end else begin
        present_next[w] = moved[15:0];
      end
    end

    always_comb begin
      case (pattern[w])
        SGN_POS: goal_next[w] = $signed({1'b0, pulse_mag});
        SGN_NEG: goal_next[w] = -$signed({1'b0, pulse_mag});
        default: goal_next[w] = '0;
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_coefficient <= COEF_RESET;
    end else if (cfg_we) begin
      ramp_coefficient <= cfg_wdata;
    end
  end

  // Input register: load on accept, drop once the item has retired.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_command  <= s_axis_tuser[0];
      in_motion   <= s_axis_tdata[3:0];
      in_speed    <= s_axis_tdata[14:4];
      in_interval <= s_axis_tdata[30:15];
    end
  end

  // Motion state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MV_IDLE;
      for (int w = 0; w < WHEELS; w++) begin
        present_pulse[w] <= '0;
        goal_pulse[w]    <= '0;
      end
    end else if (advance) begin
      if (is_tick) begin
        for (int w = 0; w < WHEELS; w++) begin
          present_pulse[w] <= present_next[w];
        end
      end else begin
        for (int w = 0; w < WHEELS; w++) begin
          goal_pulse[w] <= goal_next[w];
        end
        if (is_stop) begin
          // Stop keeps the pulses; they ramp down on later ticks.
          mode <= MV_IDLE;
        end else if (in_motion != mode) begin
          // New motion kind starts from rest.
          mode <= in_motion;
          for (int w = 0; w < WHEELS; w++) begin
            present_pulse[w] <= '0;
          end
        end
      end
    end
  end

  // Result register: hold until taken, reload on each retired tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tick) begin
      out_data <= {present_next[3], present_next[2], present_next[1], present_next[0]};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign tick_done   = advance && is_tick;
  assign motion_done = advance && !is_tick;
  assign new_mode    = motion_done && !is_stop && (in_motion != mode);
  assign goal_idle   = (mode == MV_IDLE) && (goal_pulse[0] == 0) && (goal_pulse[1] == 0) &&
                       (goal_pulse[2] == 0) && (goal_pulse[3] == 0);
  assign pulse_zero  = (present_pulse[0] == 0) && (present_pulse[1] == 0) &&
                       (present_pulse[2] == 0) && (present_pulse[3] == 0);

  `MMR_ASSERT_NEXT(ast_tick_gives_result, tick_done, m_axis_tvalid, "tick lost")
  `MMR_ASSERT_NEXT(ast_no_stray_result, !out_valid && !tick_done, !out_valid, "stray result")
  `MMR_ASSERT_NEXT(ast_stop_clears_goal, motion_done && is_stop, goal_idle, "stop left a target")
  `MMR_ASSERT_NEXT(ast_mode_change_rest, new_mode, pulse_zero, "mode change kept pulses")
  `MMR_ASSERT_SAME(ast_ready_when_drained, !m_axis_tvalid, s_axis_tready, "stall while drained")

endmodule

/* verif/mecanum_motion_ramp_checker.sv */
module mecanum_motion_ramp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [3:0] motion, [14:4] speed, [30:15] interval, [31] zero
  input  logic [0:0]  s_axis_tuser,   // [0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [15:0] drive_0 .. [63:48] drive_3
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_count,
  output int          drives_checked
);
  import mmr_pkg::*;

  localparam int PULSE_PER_SPEED = 16;
  localparam int MAX_REPORTS     = 10;

  typedef logic signed [15:0] pulse_t;
  typedef pulse_t [WHEELS-1:0] drives_t;
  typedef sign_t dirs_t [WHEELS];

  logic [7:0] ramp_coef;
  logic [3:0] active_motion;
  int         wheel_pulse [WHEELS];
  int         wheel_goal  [WHEELS];
  drives_t    drive_fifo  [$];
  drives_t    want;
  drives_t    seen;

  // Wheel directions per motion code, wheel 0 first.
  function automatic dirs_t wheel_dirs(input logic [3:0] code);
    dirs_t d;
    case (code)
      MV_AHEAD:    d = '{SGN_POS,  SGN_POS,  SGN_POS,  SGN_POS};
      MV_REVERSE:  d = '{SGN_NEG,  SGN_NEG,  SGN_NEG,  SGN_NEG};
      MV_SLIDE_L:  d = '{SGN_NEG,  SGN_POS,  SGN_POS,  SGN_NEG};
      MV_SLIDE_R:  d = '{SGN_POS,  SGN_NEG,  SGN_NEG,  SGN_POS};
      MV_DIAG_FR:  d = '{SGN_POS,  SGN_ZERO, SGN_ZERO, SGN_POS};
      MV_DIAG_FL:  d = '{SGN_ZERO, SGN_POS,  SGN_POS,  SGN_ZERO};
      MV_DIAG_RR:  d = '{SGN_ZERO, SGN_NEG,  SGN_NEG,  SGN_ZERO};
      MV_DIAG_RL:  d = '{SGN_NEG,  SGN_ZERO, SGN_ZERO, SGN_NEG};
      MV_SPIN_L:   d = '{SGN_POS,  SGN_NEG,  SGN_POS,  SGN_NEG};
      MV_SPIN_R:   d = '{SGN_NEG,  SGN_POS,  SGN_NEG,  SGN_POS};
      MV_PIVOT_FR: d = '{SGN_NEG,  SGN_POS,  SGN_ZERO, SGN_ZERO};
      MV_PIVOT_FL: d = '{SGN_POS,  SGN_NEG,  SGN_ZERO, SGN_ZERO};
      MV_PIVOT_RR: d = '{SGN_ZERO, SGN_ZERO, SGN_NEG,  SGN_POS};
      MV_PIVOT_RL: d = '{SGN_ZERO, SGN_ZERO, SGN_POS,  SGN_NEG};
      default:     d = '{SGN_ZERO, SGN_ZERO, SGN_ZERO, SGN_ZERO};
    endcase
    return d;
  endfunction

  task automatic set_targets(input logic [3:0] code, input logic [10:0] speed);
    int    p;
    dirs_t d;
    p = int'(speed) * PULSE_PER_SPEED;
    d = wheel_dirs(code);
    if (code == MV_IDLE || code == MV_HALT) begin
      // Zero the targets but keep the pulses: they ramp down on later ticks.
      foreach (wheel_goal[w]) wheel_goal[w] = 0;
      active_motion = MV_IDLE;
      return;
    end
    foreach (wheel_goal[w]) begin
      case (d[w])
        SGN_POS: wheel_goal[w] = p;
        SGN_NEG: wheel_goal[w] = -p;
        default: wheel_goal[w] = 0;
      endcase
    end
    if (active_motion != code) begin
      foreach (wheel_pulse[w]) wheel_pulse[w] = 0;
      active_motion = code;
    end
  endtask

  task automatic ramp_wheels(input logic [15:0] interval, output drives_t drv);
    int unsigned prod;
    int          step;
    int          nxt;
    int          gap;
    prod = ramp_coef * interval;
    step = (prod > STEP_MAX) ? int'(STEP_MAX) : int'(prod);
    foreach (wheel_pulse[w]) begin
      if (wheel_pulse[w] != wheel_goal[w]) begin
        nxt = (wheel_goal[w] > wheel_pulse[w]) ? wheel_pulse[w] + step
                                               : wheel_pulse[w] - step;
        gap = nxt - wheel_goal[w];
        if (gap < 0) gap = -gap;
        if (gap <= step) nxt = wheel_goal[w];
        wheel_pulse[w] = nxt;
      end
      drv[w] = pulse_t'(wheel_pulse[w]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ramp_coef      = COEF_RESET;
      active_motion  = MV_IDLE;
      foreach (wheel_pulse[w]) begin
        wheel_pulse[w] = 0;
        wheel_goal[w]  = 0;
      end
      drive_fifo.delete();
      fail_count     = 0;
      drives_checked = 0;
    end else begin
      if (cfg_we) ramp_coef = cfg_wdata;
      // Check the output before predicting: a new tick cannot leave this early.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (drive_fifo.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("checker: drive item with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = drive_fifo.pop_front();
          for (int w = 0; w < WHEELS; w++) begin
            if (seen[w] !== want[w]) begin
              if (fail_count < MAX_REPORTS)
                $display("checker: drive_%0d expected %0d got %0d (item %0d)",
                         w, want[w], seen[w], drives_checked);
              fail_count++;
            end
          end
          drives_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CMD_TICK) begin
          ramp_wheels(s_axis_tdata[30:15], want);
          drive_fifo.push_back(want);
        end else begin
          set_targets(s_axis_tdata[3:0], s_axis_tdata[14:4]);
        end
      end
    end
    pending_count = drive_fifo.size();
  end

endmodule

/* verif/mecanum_motion_ramp_core_tb.sv */
module mecanum_motion_ramp_core_tb;
  import mmr_pkg::*;

  // Slowest item: the largest idle draw on the input and on the output plus
  // the input and result registers. Roughly 1100 items stay far below this.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 180;
  // Give motion items this long to drain.
  localparam int SETTLE_CYCLES    = 4;
  localparam int DRAIN_CYCLES     = 10;
  localparam int NUM_PHASES       = 6;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  int          fail_count;
  int          pending_count;
  int          drives_checked;

  int          cycle_count = 0;
  int          motions_sent;
  int          ticks_sent;
  int          coef_writes;
  logic        steady;      // high: neither side idles
  logic [7:0]  coef_now;    // shadow of the ramp coefficient for shaping intervals

  mecanum_motion_ramp_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  mecanum_motion_ramp_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .drives_checked (drives_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Draw the idle cycles in front of one item; none during steady phases.
  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  // Favor the two speed extremes, otherwise pick anything.
  function automatic logic [10:0] draw_speed();
    case ($urandom_range(0, 5))
      0:       return 11'd0;
      1:       return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // Keep most steps small against the coefficient so ramps take several ticks,
  // but mix in zero, full scale and fully random intervals.
  function automatic logic [15:0] draw_interval();
    int reach;
    reach = (coef_now == 8'd0) ? 65535 : 6000 / int'(coef_now) + 1;
    case ($urandom_range(0, 9))
      0:       return 16'hffff;
      1:       return 16'd0;
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, reach));
    endcase
  endfunction

  // Present one item, called and returning at a falling edge. Hold tvalid
  // high into the next item when no idle cycles are drawn.
  task automatic push_item(input logic cmd, input logic [3:0] motion,
                           input logic [10:0] speed, input logic [15:0] interval);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, interval, speed, motion};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (cmd == CMD_TICK) ticks_sent++;
    else motions_sent++;
  endtask

  // Fill the unused fields with noise so their bits still toggle.
  task automatic push_motion(input logic [3:0] code, input logic [10:0] speed);
    push_item(CMD_MOTION, code, speed, 16'($urandom));
  endtask

  task automatic push_tick(input logic [15:0] interval);
    push_item(CMD_TICK, 4'($urandom), 11'($urandom), interval);
  endtask

  // Write the coefficient only once the block has gone quiet.
  task automatic write_coef(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 8'($urandom);
    coef_now  = value;
    coef_writes++;
  endtask

  // Drive extremes, every motion code and the special cases by hand.
  task automatic directed_items();
    // Tick straight out of reset: everything sits at zero.
    push_tick(16'd0);
    // Full speed ahead with a saturated step: snap straight to the target.
    push_motion(MV_AHEAD, 11'd2047);
    push_tick(16'hffff);
    // Same motion again: keep the pulses, take the new (zero) targets.
    push_motion(MV_AHEAD, 11'd0);
    push_tick(16'd100);
    // New motion clears the pulses; a zero interval leaves them parked.
    push_motion(MV_REVERSE, 11'd2047);
    push_tick(16'd0);
    push_tick(16'd1000);
    // Halt keeps the pulses, which then ramp back toward zero.
    push_motion(MV_HALT, 11'd2047);
    push_tick(16'd300);
    push_motion(MV_IDLE, 11'd5);
    push_tick(16'hffff);
    // Walk the remaining patterns, alternating top speed and a speed of one.
    for (int code = MV_SLIDE_L; code <= MV_PIVOT_RL; code++) begin
      push_motion(4'(code), (code % 2) ? 11'd2047 : 11'd1);
      push_tick((code % 3 == 0) ? 16'hffff : 16'd20000);
    end
  endtask

  // Mostly well-formed runs: a motion, then a few ticks, now and then a speed
  // change on the same motion or a stray motion item.
  task automatic random_items(input int count);
    int         sent;
    int         run_len;
    logic [3:0] code;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0)
        code = $urandom_range(0, 1) ? MV_IDLE : MV_HALT;
      else
        code = 4'($urandom_range(1, 14));
      push_motion(code, draw_speed());
      sent++;
      run_len = $urandom_range(1, 6);
      repeat (run_len) begin
        case ($urandom_range(0, 9))
          0:       push_motion(code, draw_speed());
          1:       push_motion(4'($urandom_range(0, 15)), draw_speed());
          default: push_tick(draw_interval());
        endcase
        sent++;
      end
    end
  endtask

  // Receiver: stall a random number of cycles before taking each result.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog: give up if the run stalls.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: timeout after %0d cycles, %0d drive items outstanding",
             cycle_count, pending_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] coef_plan [NUM_PHASES];
    motions_sent  = 0;
    ticks_sent    = 0;
    coef_writes   = 0;
    steady        = 1'b0;
    coef_now      = COEF_RESET;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_MOTION;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    // Sweep the extremes first, then a few values in between.
    coef_plan[0] = 8'd255;
    coef_plan[1] = 8'd0;
    coef_plan[2] = 8'd1;
    coef_plan[3] = 8'd128;
    coef_plan[4] = 8'($urandom_range(2, 254));
    coef_plan[5] = 8'($urandom_range(2, 31));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_items();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_coef(coef_plan[ph]);
      // Run phases 2 and 4 with no idling on either side.
      steady = (ph == 2 || ph == 4);
      random_items(RANDOM_PER_PHASE);
    end

    // Drop valid, drain the outstanding results, then linger a little.
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb: sent %0d motion and %0d tick items across %0d coefficient writes",
             motions_sent, ticks_sent, coef_writes);
    $display("tb: compared %0d drive items, %0d mismatches", drives_checked, fail_count);
    if (fail_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mmr_pkg.sv
rtl/mecanum_motion_ramp_core.sv
verif/mecanum_motion_ramp_checker.sv
verif/mecanum_motion_ramp_core_tb.sv
